// ----- rtl/rbep_pkg.sv -----
package rbep_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned DIR_W = 24;
  localparam int unsigned MAG_W = 24;
  localparam int unsigned NUM_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned QUO_W = NUM_W + FRAC_W;
  localparam int unsigned MARGIN_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgBoxXLow  = 3'd0,
    CfgBoxXHigh = 3'd1,
    CfgBoxYLow  = 3'd2,
    CfgBoxYHigh = 3'd3,
    CfgBoxZLow  = 3'd4,
    CfgBoxZHigh = 3'd5,
    CfgMargin   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] start_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } rbep_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] exit_x;
    logic signed [POS_W-1:0] exit_y;
    logic signed [POS_W-1:0] exit_z;
    logic                    outside_box;
  } rbep_out_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0]  box_lo;
    logic [2:0][POS_W-1:0]  box_hi;
    logic [MARGIN_W-1:0]    margin;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             neg;
    logic             zero;
    logic [MAG_W-1:0] mag;
    logic [NUM_W-1:0] num;
  } axis_t;

  typedef struct packed {
    logic             outside;
    axis_t [2:0]      ax;
  } cls_t;

endpackage

// ----- rtl/ray_box_exit_projection.sv -----
// Ray to box exit projection. Each item carries a Q23.8 start point and a
// signed direction; the block shrinks the configured box by the edge margin,
// flags points outside it with zero coordinates, and otherwise returns the
// start point moved along the direction to the nearest facing wall, saturated
// to 32 bits; if no single wall is strictly nearest, the start point returns
// unmoved. One item is accepted per clock cycle and one result leaves per
// cycle while neither side stalls; each axis distance comes from the 48-stage
// restoring divider, one quotient bit per stage. Configuration writes take
// effect at once and should only be made while no item is in flight.
module ray_box_exit_projection #(
  parameter int unsigned MidDepth = rbep_pkg::MID_DEPTH,
  parameter int unsigned OutDepth = rbep_pkg::OUT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rbep_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  rbep_pkg::rbep_in_t                in_data_i,
  output logic                              empty,
  input  logic                              pop,
  output rbep_pkg::rbep_out_t               out_data_o
);

  import rbep_pkg::*;

  cfg_t      cfg_q;
  logic      mid_push, mid_full, mid_empty, mid_pop;
  cls_t      mid_in, mid_out;
  logic      out_push, out_full;
  rbep_out_t out_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBoxXLow:  cfg_q.box_lo[0] <= cfg_data_i;
        CfgBoxXHigh: cfg_q.box_hi[0] <= cfg_data_i;
        CfgBoxYLow:  cfg_q.box_lo[1] <= cfg_data_i;
        CfgBoxYHigh: cfg_q.box_hi[1] <= cfg_data_i;
        CfgBoxZLow:  cfg_q.box_lo[2] <= cfg_data_i;
        CfgBoxZHigh: cfg_q.box_hi[2] <= cfg_data_i;
        CfgMargin:   cfg_q.margin    <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  rbep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .data_i     (in_data_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_in),
    .mid_full_i (mid_full)
  );

  rbep_fifo #(
    .Width ($bits(cls_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  rbep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_in)
  );

  rbep_fifo #(
    .Width ($bits(rbep_out_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

// ----- rtl/rbep_fifo.sv -----
module rbep_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/rbep_front.sv -----
module rbep_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbep_pkg::cfg_t    cfg_i,
  input  logic              push_i,
  input  rbep_pkg::rbep_in_t data_i,
  output logic              full_o,
  output logic              mid_push_o,
  output rbep_pkg::cls_t    mid_data_o,
  input  logic              mid_full_i
);

  import rbep_pkg::*;

  localparam int unsigned ExtW = POS_W + 2;

  logic [2:0][POS_W-1:0] pos;
  logic [2:0][DIR_W-1:0] dir;
  cls_t                  cls;
  cls_t                  fr_q;
  logic                  fr_v_q, fr_v_d;
  logic                  accept;

  assign pos = {data_i.start_z, data_i.start_y, data_i.start_x};
  assign dir = {data_i.dir_z, data_i.dir_y, data_i.dir_x};

  always_comb begin
    logic signed [ExtW-1:0] lo, hi, p;
    logic [ExtW-1:0]        diff;
    cls.outside = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p    = ExtW'($signed(pos[k]));
      lo   = ExtW'($signed(cfg_i.box_lo[k])) + $signed({2'b00, 16'h0, cfg_i.margin});
      hi   = ExtW'($signed(cfg_i.box_hi[k])) - $signed({2'b00, 16'h0, cfg_i.margin});
      if (p < lo || p > hi) begin
        cls.outside = 1'b1;
      end
      diff = dir[k][DIR_W-1] ? ExtW'(p - lo) : ExtW'(hi - p);
      cls.ax[k].pos  = pos[k];
      cls.ax[k].neg  = dir[k][DIR_W-1];
      cls.ax[k].zero = (dir[k] == '0);
      cls.ax[k].mag  = dir[k][DIR_W-1] ? MAG_W'(-dir[k]) : MAG_W'(dir[k]);
      cls.ax[k].num  = diff[NUM_W-1:0];
    end
  end

  assign full_o     = fr_v_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = fr_v_q;
  assign mid_data_o = fr_q;
  assign fr_v_d     = accept ? 1'b1 : (fr_v_q && mid_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= fr_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q <= cls;
    end
  end

endmodule

// ----- rtl/rbep_div.sv -----
module rbep_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rbep_pkg::NUM_W-1:0]   num_i,
  input  logic [rbep_pkg::MAG_W-1:0]   div_i,
  output logic [rbep_pkg::QUO_W-1:0]   quo_o
);

  import rbep_pkg::*;

  logic [MAG_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] dvd_q [QUO_W];
  logic [MAG_W-1:0] dsr_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [MAG_W-1:0] rem_in, dsr_in;
    logic [QUO_W-1:0] quo_in, dvd_in;
    logic [MAG_W:0]   trial, diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = {num_i, {FRAC_W{1'b0}}};
      assign dsr_in = (div_i == '0) ? MAG_W'(1) : div_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dvd_in = dvd_q[s-1];
      assign dsr_in = dsr_q[s-1];
    end

    assign trial = {rem_in, dvd_in[QUO_W-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign ge    = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        quo_q[s] <= {quo_in[QUO_W-2:0], ge};
        dvd_q[s] <= {dvd_in[QUO_W-2:0], 1'b0};
        dsr_q[s] <= dsr_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ----- rtl/rbep_back.sv -----
module rbep_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_empty_i,
  input  rbep_pkg::cls_t      mid_data_i,
  output logic                mid_pop_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output rbep_pkg::rbep_out_t out_data_o
);

  import rbep_pkg::*;

  localparam int unsigned Lat   = QUO_W + 4;
  localparam int unsigned SideN = QUO_W + 3;
  localparam int unsigned HalfW = QUO_W / 2;
  localparam int unsigned StepW = NUM_W + 1;
  localparam int unsigned SumW  = POS_W + 3;

  logic               en;
  logic [Lat-1:0]     v_q;
  cls_t               side_q [SideN];
  logic [2:0][QUO_W-1:0] quo;
  logic [QUO_W:0]     reach [3];
  logic [QUO_W-1:0]   t_d, t_q;
  logic [2*HalfW-1:0] pp_lo_q [3];
  logic [2*HalfW-1:0] pp_hi_q [3];
  logic [StepW-1:0]   step_q [3];
  rbep_out_t          res_d, res_q;

  assign en         = !v_q[Lat-1] || !out_full_i;
  assign mid_pop_o  = en && !mid_empty_i;
  assign out_push_o = v_q[Lat-1];
  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], !mid_empty_i};
    end
  end

  for (genvar i = 0; i < SideN; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[i] <= (i == 0) ? mid_data_i : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    rbep_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (mid_data_i.ax[k].num),
      .div_i (mid_data_i.ax[k].mag),
      .quo_o (quo[k])
    );
    assign reach[k] = side_q[QUO_W-1].ax[k].zero ? '1 : {1'b0, quo[k]};
  end

  always_comb begin
    priority if (reach[0] < reach[1] && reach[0] < reach[2]) begin
      t_d = reach[0][QUO_W-1:0];
    end else if (reach[1] < reach[2] && reach[1] < reach[0]) begin
      t_d = reach[1][QUO_W-1:0];
    end else if (reach[2] < reach[0] && reach[2] < reach[1]) begin
      t_d = reach[2][QUO_W-1:0];
    end else begin
      t_d = '0;
    end
  end

  always_comb begin
    logic signed [SumW-1:0]   sum, s;
    logic [2:0][POS_W-1:0]    ex;
    for (int k = 0; k < 3; k++) begin
      s   = $signed({{(SumW-StepW){1'b0}}, step_q[k]});
      if (side_q[SideN-1].ax[k].neg) begin
        s = -s;
      end
      sum = SumW'($signed(side_q[SideN-1].ax[k].pos)) + s;
      if (sum > $signed(SumW'({1'b0, {(POS_W-1){1'b1}}}))) begin
        ex[k] = {1'b0, {(POS_W-1){1'b1}}};
      end else if (sum < -$signed(SumW'({1'b1, {(POS_W-1){1'b0}}}))) begin
        ex[k] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        ex[k] = sum[POS_W-1:0];
      end
    end
    if (side_q[SideN-1].outside) begin
      res_d = '{exit_x: '0, exit_y: '0, exit_z: '0, outside_box: 1'b1};
    end else begin
      res_d = '{exit_x: ex[0], exit_y: ex[1], exit_z: ex[2], outside_box: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= t_d;
      for (int k = 0; k < 3; k++) begin
        pp_lo_q[k] <= side_q[QUO_W].ax[k].mag * t_q[HalfW-1:0];
        pp_hi_q[k] <= side_q[QUO_W].ax[k].mag * t_q[QUO_W-1:HalfW];
        step_q[k]  <= StepW'(({{HalfW{1'b0}}, pp_lo_q[k]} +
                              {pp_hi_q[k], {HalfW{1'b0}}}) >> FRAC_W);
      end
      res_q <= res_d;
    end
  end

endmodule

// ----- tb/rbep_checker.sv -----
`timescale 1ns / 1ps

module rbep_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbep_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbep_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  rbep_pkg::rbep_in_t              in_data_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  rbep_pkg::rbep_out_t             out_data_i,
  output int                              in_flight_o,
  output int                              errors_o
);
  import rbep_pkg::*;

  longint            wall_lo[3];
  longint            wall_hi[3];
  longint            margin;
  rbep_out_t         expected_exits[$];

  function automatic longint signed clamp32(longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic rbep_out_t project(rbep_in_t it);
    longint signed   p[3];
    longint signed   d[3];
    longint signed   lo[3];
    longint signed   hi[3];
    longint unsigned reach[3];
    longint unsigned num;
    longint unsigned mag;
    longint unsigned t;
    longint unsigned step;
    longint signed   moved[3];
    bit              outside;
    rbep_out_t       r;
    p[0] = longint'($signed(it.start_x));
    p[1] = longint'($signed(it.start_y));
    p[2] = longint'($signed(it.start_z));
    d[0] = longint'($signed(it.dir_x));
    d[1] = longint'($signed(it.dir_y));
    d[2] = longint'($signed(it.dir_z));
    outside = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo[i] = wall_lo[i] + margin;
      hi[i] = wall_hi[i] - margin;
      if (p[i] < lo[i] || p[i] > hi[i]) outside = 1'b1;
    end
    r = '0;
    if (outside) begin
      r.outside_box = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) begin
        reach[i] = '1;
      end else begin
        num = (d[i] > 0) ? longint'(hi[i] - p[i]) : longint'(p[i] - lo[i]);
        mag = (d[i] < 0) ? -d[i] : d[i];
        reach[i] = (num << 16) / mag;
      end
    end
    t = 0;
    if (reach[0] < reach[1] && reach[0] < reach[2]) t = reach[0];
    else if (reach[1] < reach[2] && reach[1] < reach[0]) t = reach[1];
    else if (reach[2] < reach[0] && reach[2] < reach[1]) t = reach[2];
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      step = (mag * t) >> 16;
      moved[i] = clamp32(d[i] < 0 ? p[i] - longint'(step) : p[i] + longint'(step));
    end
    r.exit_x = moved[0][31:0];
    r.exit_y = moved[1][31:0];
    r.exit_z = moved[2][31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rbep_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        wall_lo[i] = 0;
        wall_hi[i] = 0;
      end
      margin = 0;
      expected_exits.delete();
      in_flight_o = 0;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBoxXLow:  wall_lo[0] = longint'($signed(cfg_data_i));
          CfgBoxXHigh: wall_hi[0] = longint'($signed(cfg_data_i));
          CfgBoxYLow:  wall_lo[1] = longint'($signed(cfg_data_i));
          CfgBoxYHigh: wall_hi[1] = longint'($signed(cfg_data_i));
          CfgBoxZLow:  wall_lo[2] = longint'($signed(cfg_data_i));
          CfgBoxZHigh: wall_hi[2] = longint'($signed(cfg_data_i));
          CfgMargin:   margin = longint'(cfg_data_i[MARGIN_W-1:0]);
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (expected_exits.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          errors_o++;
        end else begin
          want = expected_exits.pop_front();
          if (want.exit_x !== out_data_i.exit_x) begin
            $display("%0t: exit_x expected %h actual %h", $time, want.exit_x,
                     out_data_i.exit_x);
            errors_o++;
          end
          if (want.exit_y !== out_data_i.exit_y) begin
            $display("%0t: exit_y expected %h actual %h", $time, want.exit_y,
                     out_data_i.exit_y);
            errors_o++;
          end
          if (want.exit_z !== out_data_i.exit_z) begin
            $display("%0t: exit_z expected %h actual %h", $time, want.exit_z,
                     out_data_i.exit_z);
            errors_o++;
          end
          if (want.outside_box !== out_data_i.outside_box) begin
            $display("%0t: outside_box expected %b actual %b", $time,
                     want.outside_box, out_data_i.outside_box);
            errors_o++;
          end
        end
      end
      if (push_i && !full_i) expected_exits.push_back(project(in_data_i));
      in_flight_o = expected_exits.size();
    end
  end

endmodule

// ----- tb/ray_box_exit_projection_test.sv -----
`timescale 1ns / 1ps

module ray_box_exit_projection_test;
  import rbep_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  rbep_in_t              in_data_i;
  logic                  empty;
  logic                  pop;
  rbep_out_t             out_data_o;
  int                    in_flight;
  int                    errors;
  bit                    calm;
  int                    pop_stall;
  longint                shrunk_lo[3];
  longint                shrunk_hi[3];
  longint                raw_lo[3];
  longint                raw_hi[3];
  longint                cur_margin;

  ray_box_exit_projection DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .in_data_i, .empty, .pop, .out_data_o
  );

  rbep_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .full_i(full), .in_data_i, .empty_i(empty), .pop_i(pop),
    .out_data_i(out_data_o), .in_flight_o(in_flight), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      pop <= rst_ni;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else if ($urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_stall = $urandom_range(0, 13);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, longint value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[31:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(longint lo[3], longint hi[3], longint m);
    @(negedge clk_i);
    push <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    write_reg(CfgBoxXLow, lo[0]);
    write_reg(CfgBoxXHigh, hi[0]);
    write_reg(CfgBoxYLow, lo[1]);
    write_reg(CfgBoxYHigh, hi[1]);
    write_reg(CfgBoxZLow, lo[2]);
    write_reg(CfgBoxZHigh, hi[2]);
    write_reg(CfgMargin, m);
    for (int i = 0; i < 3; i++) begin
      shrunk_lo[i] = lo[i] + m;
      shrunk_hi[i] = hi[i] - m;
    end
  endtask

  task automatic send(rbep_in_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  function automatic logic [31:0] pick_pos(int axis);
    longint v;
    longint span;
    case ($urandom_range(0, 9))
      0: v = longint'($signed($urandom()));
      1: v = shrunk_lo[axis];
      2: v = shrunk_hi[axis];
      3: v = shrunk_lo[axis] - 1;
      4: v = shrunk_hi[axis] + 1;
      default: begin
        if (shrunk_lo[axis] <= shrunk_hi[axis]) begin
          span = shrunk_hi[axis] - shrunk_lo[axis] + 1;
          v = shrunk_lo[axis] + longint'({$urandom(), $urandom()} % span);
        end else begin
          v = longint'($signed($urandom()));
        end
      end
    endcase
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = longint'($signed($urandom()));
    return v[31:0];
  endfunction

  function automatic logic [23:0] pick_dir();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 24'd0;
      1: return 24'h7fffff;
      2: return 24'h800000;
      3: return 24'($signed($urandom_range(0, 32)) - 16);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic rbep_in_t make_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [23:0] dx, logic [23:0] dy, logic [23:0] dz);
    rbep_in_t it;
    it.start_x = x;
    it.start_y = y;
    it.start_z = z;
    it.dir_x = dx;
    it.dir_y = dy;
    it.dir_z = dz;
    return it;
  endfunction

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send(make_item($urandom(), $urandom(), $urandom(), 24'($urandom()),
                       24'($urandom()), 24'($urandom())));
      else
        send(make_item(pick_pos(0), pick_pos(1), pick_pos(2), pick_dir(), pick_dir(),
                       pick_dir()));
    end
  endtask

  task automatic directed_items();
    send(make_item(32'd0, 32'd0, 32'd0, 24'd0, 24'd0, 24'd0));
    send(make_item(32'd0, 32'd0, 32'd0, 24'h7fffff, 24'h800000, 24'd1));
    send(make_item(32'd1000, 32'hfffffc18, 32'd0, 24'h7fffff, 24'h7fffff, 24'd0));
    send(make_item(32'd0, 32'd0, 32'd0, 24'h000003, 24'hfffffd, 24'd0));
    send(make_item(32'(shrunk_lo[0]), 32'(shrunk_lo[1]), 32'(shrunk_lo[2]), 24'h800000,
                   24'h7fffff, 24'd5));
    send(make_item(32'(shrunk_hi[0]), 32'(shrunk_hi[1]), 32'(shrunk_hi[2]), 24'h7fffff,
                   24'hffffff, 24'd0));
    send(make_item(32'(shrunk_lo[0] - 1), 32'd0, 32'd0, 24'd1, 24'd1, 24'd1));
    send(make_item(32'd0, 32'(shrunk_hi[1] + 1), 32'd0, 24'd1, 24'd1, 24'd1));
    send(make_item(32'd0, 32'd0, 32'(shrunk_lo[2] - 1), 24'd1, 24'd1, 24'd1));
    send(make_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'h7fffff, 24'h800000,
                   24'h7fffff));
    send(make_item(32'h80000000, 32'h7fffffff, 32'h80000000, 24'h800000, 24'h7fffff,
                   24'h800000));
    send(make_item(32'd17, 32'hffffffef, 32'd300, 24'h000001, 24'hffffff, 24'h000200));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    push = 1'b0;
    in_data_i = '0;
    calm = 1'b0;
    pop_stall = 0;
    for (int i = 0; i < 3; i++) begin
      shrunk_lo[i] = 0;
      shrunk_hi[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    random_items(60);

    raw_lo = '{-1000000, -50000, -3000};
    raw_hi = '{1000000, 50000, 70000};
    set_box(raw_lo, raw_hi, 100);
    directed_items();
    random_items(150);

    raw_lo = '{-2147483648, -2147483648, -2147483648};
    raw_hi = '{2147483647, 2147483647, 2147483647};
    set_box(raw_lo, raw_hi, 0);
    random_items(150);
    set_box(raw_lo, raw_hi, 65535);
    random_items(150);

    raw_lo = '{5, 5, -100};
    raw_hi = '{-5, 300, 100};
    set_box(raw_lo, raw_hi, 0);
    random_items(80);

    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 3; i++) begin
        raw_lo[i] = longint'($signed($urandom()));
        raw_hi[i] = longint'($signed($urandom()));
        if ($urandom_range(0, 1)) raw_hi[i] = raw_lo[i] + $urandom_range(0, 400000);
        if (raw_hi[i] > 64'sd2147483647) raw_hi[i] = 64'sd2147483647;
        if (raw_lo[i] > raw_hi[i]) begin
          cur_margin = raw_lo[i];
          raw_lo[i] = raw_hi[i];
          raw_hi[i] = cur_margin;
        end
      end
      cur_margin = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 64);
      set_box(raw_lo, raw_hi, cur_margin);
      if (ph == 4) calm = 1'b1;
      random_items(150);
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
